/* src/mst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types, constants and lookup tables for the marching-squares cell
// triangulator: vertex selects, per-case triangle tables, register indexes.
// ----------------------------------------------------------------------------
package mst_pkg;

  // Fixed field widths
  localparam int IDX_W      = 18;  // vertex index port width
  localparam int OFF_W      = 20;  // index-buffer offset width
  localparam int CFG_IDX_W  = 4;   // config register index width
  localparam int CFG_DATA_W = 18;  // config write data width (widest register)
  localparam int NUM_VTX    = 8;   // candidate vertices per cell

  // Parameter defaults
  localparam int DEF_MAX_GRID   = 256;
  localparam int DEF_INDEX_BITS = 18;

  // Register reset values
  localparam logic [7:0]       RST_THRESHOLD  = 8'd128;
  localparam logic [8:0]       RST_GRID_WIDTH = 9'd256;
  localparam logic [IDX_W-1:0] RST_HORIZ_BASE = 18'd65536;
  localparam logic [IDX_W-1:0] RST_VERT_BASE  = 18'd130816;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD  = 4'd0,
    REG_GRID_WIDTH = 4'd1,
    REG_HORIZ_BASE = 4'd2,
    REG_VERT_BASE  = 4'd3
  } cfg_reg_t;

  // Vertex selects: four corners, two horizontal-edge, two vertical-edge
  typedef enum logic [2:0] {
    SEL_C0 = 3'd0,
    SEL_C1 = 3'd1,
    SEL_C2 = 3'd2,
    SEL_C3 = 3'd3,
    SEL_H0 = 3'd4,
    SEL_H1 = 3'd5,
    SEL_V0 = 3'd6,
    SEL_V1 = 3'd7
  } sel_t;

  // Per-cell working set handed from vertex stage to slot emitter
  typedef struct packed {
    logic [3:0]                      code;
    logic [NUM_VTX-1:0][IDX_W-1:0]   vtx;
    logic [OFF_W-1:0]                base_off;
  } cell_t;

  // Triangles used per case
  localparam logic [2:0] TRI_CNT [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd4, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd4, 3'd3, 3'd2, 3'd3, 3'd3, 3'd2
  };

  // Vertex selects per case, slot and corner of triangle
  localparam sel_t TRI_SEL [16][4][3] = '{
    '{'{SEL_C0, SEL_C0, SEL_C0}, '{SEL_C0, SEL_C0, SEL_C0},
      '{SEL_C0, SEL_C0, SEL_C0}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_C0, SEL_H0, SEL_V0}, '{SEL_C0, SEL_C0, SEL_C0},
      '{SEL_C0, SEL_C0, SEL_C0}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_V1, SEL_C1, SEL_H0}, '{SEL_C0, SEL_C0, SEL_C0},
      '{SEL_C0, SEL_C0, SEL_C0}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_C1, SEL_V0, SEL_C0}, '{SEL_C1, SEL_V1, SEL_V0},
      '{SEL_C0, SEL_C0, SEL_C0}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_C2, SEL_H1, SEL_V1}, '{SEL_C0, SEL_C0, SEL_C0},
      '{SEL_C0, SEL_C0, SEL_C0}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_C0, SEL_H0, SEL_V0}, '{SEL_C2, SEL_H1, SEL_V1},
      '{SEL_H0, SEL_H1, SEL_V0}, '{SEL_H0, SEL_V1, SEL_H1}},
    '{'{SEL_C2, SEL_H0, SEL_C1}, '{SEL_C2, SEL_H1, SEL_H0},
      '{SEL_C0, SEL_C0, SEL_C0}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_C0, SEL_C1, SEL_V0}, '{SEL_C1, SEL_H1, SEL_V0},
      '{SEL_C1, SEL_C2, SEL_H1}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_C3, SEL_V0, SEL_H1}, '{SEL_C0, SEL_C0, SEL_C0},
      '{SEL_C0, SEL_C0, SEL_C0}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_C0, SEL_H1, SEL_C3}, '{SEL_C0, SEL_H0, SEL_H1},
      '{SEL_C0, SEL_C0, SEL_C0}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_C1, SEL_V1, SEL_H0}, '{SEL_C3, SEL_V0, SEL_H1},
      '{SEL_H0, SEL_V1, SEL_V0}, '{SEL_V1, SEL_H1, SEL_V0}},
    '{'{SEL_C3, SEL_C0, SEL_H1}, '{SEL_C0, SEL_V1, SEL_H1},
      '{SEL_C0, SEL_C1, SEL_V1}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_C3, SEL_V1, SEL_C2}, '{SEL_C3, SEL_V0, SEL_V1},
      '{SEL_C0, SEL_C0, SEL_C0}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_C2, SEL_C3, SEL_V1}, '{SEL_C3, SEL_H0, SEL_V1},
      '{SEL_C3, SEL_C0, SEL_H0}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_C1, SEL_C2, SEL_H0}, '{SEL_C2, SEL_V0, SEL_H0},
      '{SEL_C2, SEL_C3, SEL_V0}, '{SEL_C0, SEL_C0, SEL_C0}},
    '{'{SEL_C0, SEL_C1, SEL_C2}, '{SEL_C2, SEL_C3, SEL_C0},
      '{SEL_C0, SEL_C0, SEL_C0}, '{SEL_C0, SEL_C0, SEL_C0}}
  };

endpackage

/* src/mst_vertex.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_vertex
// Per-cell combinational stage: case code from the corner densities, the
// eight candidate vertex indices and the cell's index-buffer base offset.
// ----------------------------------------------------------------------------
module mst_vertex
  import mst_pkg::*;
#(
  parameter int MAX_GRID   = DEF_MAX_GRID,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic [7:0]       cell_col,
  input  logic [7:0]       cell_row,
  input  logic [7:0]       corner_a,
  input  logic [7:0]       corner_b,
  input  logic [7:0]       corner_c,
  input  logic [7:0]       corner_d,
  input  logic [7:0]       threshold,
  input  logic [8:0]       grid_width,
  input  logic [IDX_W-1:0] horiz_base,
  input  logic [IDX_W-1:0] vert_base,
  output cell_t            cell_info
);

  // Vertex indices wrap at INDEX_BITS, then fit the port width
  localparam logic [IDX_W-1:0] IMASK =
    (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

  logic [8:0]       w;
  logic [IDX_W-1:0] row_x, col_x, w_x, wm1_x;
  logic [IDX_W-1:0] pw, pw1, qw, qw1;
  logic [IDX_W-1:0] c0, c3, h0, h1, v0;
  logic [OFF_W-1:0] lin;

  // Clamp grid width to 2..MAX_GRID
  always_comb begin
    if (grid_width < 9'd2) begin
      w = 9'd2;
    end else if (32'(grid_width) > MAX_GRID) begin
      w = 9'(MAX_GRID);
    end else begin
      w = grid_width;
    end
  end

  // Row products; next row obtained by one more add
  always_comb begin
    row_x = IDX_W'(cell_row);
    col_x = IDX_W'(cell_col);
    w_x   = IDX_W'(w);
    wm1_x = IDX_W'(w - 9'd1);
    pw    = row_x * w_x;
    pw1   = row_x * wm1_x;
    qw    = pw + w_x;
    qw1   = pw1 + wm1_x;
  end

  // Candidate vertices and buffer offset
  always_comb begin
    c0  = col_x + pw;
    c3  = col_x + qw;
    h0  = horiz_base + col_x + pw1;
    h1  = horiz_base + col_x + qw1;
    v0  = vert_base + c0;
    lin = OFF_W'(pw1) + OFF_W'(cell_col);

    cell_info.vtx[SEL_C0] = c0 & IMASK;
    cell_info.vtx[SEL_C1] = (c0 + IDX_W'(1)) & IMASK;
    cell_info.vtx[SEL_C2] = (c3 + IDX_W'(1)) & IMASK;
    cell_info.vtx[SEL_C3] = c3 & IMASK;
    cell_info.vtx[SEL_H0] = h0 & IMASK;
    cell_info.vtx[SEL_H1] = h1 & IMASK;
    cell_info.vtx[SEL_V0] = v0 & IMASK;
    cell_info.vtx[SEL_V1] = (v0 + IDX_W'(1)) & IMASK;

    // times 12 as shift-and-add
    cell_info.base_off = (lin << 3) + (lin << 2);

    // Solid corners: strictly above threshold
    cell_info.code = {corner_d > threshold, corner_c > threshold,
                      corner_b > threshold, corner_a > threshold};
  end

endmodule

/* src/mst_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_emit
// Holds one cell's working set and walks its four triangle slots into the
// output register, one slot per beat.
// ----------------------------------------------------------------------------
module mst_emit
  import mst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_t            cell_info,
  input  logic             cell_valid,
  output logic             cell_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_slot,
  output logic [IDX_W-1:0] out_index0,
  output logic [IDX_W-1:0] out_index1,
  output logic [IDX_W-1:0] out_index2,
  output logic [3:0]       out_case_code,
  output logic [OFF_W-1:0] out_buffer_offset,
  output logic             out_last
);

  cell_t            cell_r;
  logic             cell_vld_r, cell_vld_nxt;
  logic [1:0]       slot_r, slot_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             load_out;
  logic             used;
  logic [1:0]       slot_o_r;
  logic [IDX_W-1:0] idx0_r, idx1_r, idx2_r;
  logic [IDX_W-1:0] idx0_nxt, idx1_nxt, idx2_nxt;
  logic [3:0]       code_o_r;
  logic [OFF_W-1:0] off_r, off_nxt;

  // Handshake and slot counter
  always_comb begin
    load_out    = cell_vld_r && (!out_vld_r || !out_stall);
    cell_ready  = !cell_vld_r || (load_out && (slot_r == 2'd3));
    slot_nxt    = load_out ? slot_r + 2'd1 : slot_r;
    cell_vld_nxt = cell_ready ? cell_valid : cell_vld_r;
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // Slot contents; unused slots carry zero indices
  always_comb begin
    used     = {1'b0, slot_r} < TRI_CNT[cell_r.code];
    idx0_nxt = used ? cell_r.vtx[TRI_SEL[cell_r.code][slot_r][0]] : '0;
    idx1_nxt = used ? cell_r.vtx[TRI_SEL[cell_r.code][slot_r][1]] : '0;
    idx2_nxt = used ? cell_r.vtx[TRI_SEL[cell_r.code][slot_r][2]] : '0;
    off_nxt  = cell_r.base_off + OFF_W'(slot_r) + (OFF_W'(slot_r) << 1);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_vld_r <= 1'b0;
      slot_r     <= 2'd0;
      out_vld_r  <= 1'b0;
    end else begin
      cell_vld_r <= cell_vld_nxt;
      slot_r     <= slot_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cell_ready && cell_valid) begin
      cell_r <= cell_info;
    end
    if (load_out) begin
      slot_o_r <= slot_r;
      idx0_r   <= idx0_nxt;
      idx1_r   <= idx1_nxt;
      idx2_r   <= idx2_nxt;
      code_o_r <= cell_r.code;
      off_r    <= off_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_slot          = slot_o_r;
  assign out_index0        = idx0_r;
  assign out_index1        = idx1_r;
  assign out_index2        = idx2_r;
  assign out_case_code     = code_o_r;
  assign out_buffer_offset = off_r;
  assign out_last          = (slot_o_r == 2'd3);

endmodule

/* src/marching_squares_cell_triangulator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marching_squares_cell_triangulator
// Turns one grid cell (position and four corner densities) into its four
// marching-squares triangle slots of vertex indices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one beat per cell, accepted when in_valid is high
//   and in_stall is low. Output channel (out_*): four beats per cell, slot 0
//   to slot 3, out_last marks slot 3; taken when out_valid && !out_stall.
//   Config channel (cfg_*): cfg_ready is always high; write only while the
//   block holds no unfinished cell. Unknown indexes are dropped.
// Path: a cell passes the input register, then the mst_emit cell register;
//   slot 0 then enters the output register, slots 1..3 on the next beats.
// Flow: one slot per beat while out_stall is low, set by the single output
//   register. The next cell is taken while the current
//   one is still draining, so back-to-back cells stream with no gaps.
// Reset (rst_n low, synchronous): pipeline emptied, registers back to
//   threshold 128, grid width 256, bases 65536 and 130816.
// Stall: a stalled output holds its beat; the slot walk and then the input
//   register back up and in_stall rises; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module marching_squares_cell_triangulator
  import mst_pkg::*;
#(
  parameter int MAX_GRID   = DEF_MAX_GRID,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // cell input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_cell_col,
  input  logic [7:0]            in_cell_row,
  input  logic [7:0]            in_corner_a,
  input  logic [7:0]            in_corner_b,
  input  logic [7:0]            in_corner_c,
  input  logic [7:0]            in_corner_d,
  // triangle slot output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_slot,
  output logic [IDX_W-1:0]      out_index0,
  output logic [IDX_W-1:0]      out_index1,
  output logic [IDX_W-1:0]      out_index2,
  output logic [3:0]            out_case_code,
  output logic [OFF_W-1:0]      out_buffer_offset,
  output logic                  out_last
);

  logic [7:0]       threshold_r;
  logic [8:0]       grid_width_r;
  logic [IDX_W-1:0] horiz_base_r, vert_base_r;

  logic             in_vld_r, in_vld_nxt;
  logic             in_take;
  logic [7:0]       col_r, row_r, ca_r, cb_r, cc_r, cd_r;

  cell_t            cell_info;
  logic             cell_ready;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= RST_THRESHOLD;
      grid_width_r <= RST_GRID_WIDTH;
      horiz_base_r <= RST_HORIZ_BASE;
      vert_base_r  <= RST_VERT_BASE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD:  threshold_r  <= cfg_data[7:0];
        REG_GRID_WIDTH: grid_width_r <= cfg_data[8:0];
        REG_HORIZ_BASE: horiz_base_r <= cfg_data[IDX_W-1:0];
        REG_VERT_BASE:  vert_base_r  <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_comb begin
    in_take    = !in_vld_r || cell_ready;
    in_stall   = !in_take;
    in_vld_nxt = in_take ? in_valid : in_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_valid) begin
      col_r <= in_cell_col;
      row_r <= in_cell_row;
      ca_r  <= in_corner_a;
      cb_r  <= in_corner_b;
      cc_r  <= in_corner_c;
      cd_r  <= in_corner_d;
    end
  end

  // Case code and vertex indices
  mst_vertex #(
    .MAX_GRID   (MAX_GRID),
    .INDEX_BITS (INDEX_BITS)
  ) u_vertex (
    .cell_col   (col_r),
    .cell_row   (row_r),
    .corner_a   (ca_r),
    .corner_b   (cb_r),
    .corner_c   (cc_r),
    .corner_d   (cd_r),
    .threshold  (threshold_r),
    .grid_width (grid_width_r),
    .horiz_base (horiz_base_r),
    .vert_base  (vert_base_r),
    .cell_info  (cell_info)
  );

  // Slot walk and output register
  mst_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .cell_info         (cell_info),
    .cell_valid        (in_vld_r),
    .cell_ready        (cell_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_slot          (out_slot),
    .out_index0        (out_index0),
    .out_index1        (out_index1),
    .out_index2        (out_index2),
    .out_case_code     (out_case_code),
    .out_buffer_offset (out_buffer_offset),
    .out_last          (out_last)
  );

endmodule
